### rtl/core/ipde_pkg.sv
// Shared types, widths and register codes of the infrared pulse-distance encoder.
`timescale 1ns / 1ps
`default_nettype none

package ipde_pkg;

  localparam int unsigned IPDE_BYTE_W    = 8;
  localparam int unsigned IPDE_DUR_W     = 14;
  localparam int unsigned IPDE_CFG_IDX_W = 3;
  localparam int unsigned IPDE_CFG_DAT_W = 16;
  localparam int unsigned IPDE_CMD_DEPTH = 2;
  localparam int unsigned IPDE_SEG_W     = 5;

  // Configuration register indexes.
  localparam logic [IPDE_CFG_IDX_W-1:0] REG_LEADER_LOW  = 3'd0;
  localparam logic [IPDE_CFG_IDX_W-1:0] REG_LEADER_HIGH = 3'd1;
  localparam logic [IPDE_CFG_IDX_W-1:0] REG_MARK        = 3'd2;
  localparam logic [IPDE_CFG_IDX_W-1:0] REG_SPACE_ZERO  = 3'd3;
  localparam logic [IPDE_CFG_IDX_W-1:0] REG_SPACE_ONE   = 3'd4;
  localparam logic [IPDE_CFG_IDX_W-1:0] REG_STOP_LOW    = 3'd5;

  // Segment numbering inside one byte: leader low/high, then mark/space pairs, then stop.
  localparam logic [IPDE_SEG_W-1:0] SEG_LEADER_LOW  = 5'd0;
  localparam logic [IPDE_SEG_W-1:0] SEG_LEADER_HIGH = 5'd1;
  localparam logic [IPDE_SEG_W-1:0] SEG_FIRST_MARK  = 5'd2;
  localparam logic [IPDE_SEG_W-1:0] SEG_LAST_SPACE  = 5'd17;
  localparam logic [IPDE_SEG_W-1:0] SEG_STOP        = 5'd18;

  typedef struct packed {
    logic [IPDE_DUR_W-1:0] leader_low;
    logic [IPDE_DUR_W-1:0] leader_high;
    logic [IPDE_DUR_W-1:0] mark;
    logic [IPDE_DUR_W-1:0] space_zero;
    logic [IPDE_DUR_W-1:0] space_one;
    logic [IPDE_DUR_W-1:0] stop_low;
  } ipde_cfg_t;

  // One classified byte handed from the front to the back.
  typedef struct packed {
    logic [IPDE_BYTE_W-1:0] data;
    logic                   last;
    logic                   leader;
  } ipde_cmd_t;

  typedef struct packed {
    logic                  active;
    logic [IPDE_SEG_W-1:0] seg;
  } ipde_back_stat_t;

endpackage

`default_nettype wire

### rtl/core/ipde_front.sv
// Front end: accept frame bytes, track the open frame and tag bytes that need a leader.
`timescale 1ns / 1ps
`default_nettype none

module ipde_front
  import ipde_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   push_i,
  input  wire logic [IPDE_BYTE_W-1:0] data_byte_i,
  input  wire logic                   last_byte_i,
  input  wire logic                   q_full_i,
  output      logic                   q_push_o,
  output      ipde_cmd_t              q_cmd_o
);

  logic frame_open_q, frame_open_d;

  always_comb begin
    q_push_o        = push_i && !q_full_i;
    q_cmd_o.data    = data_byte_i;
    q_cmd_o.last    = last_byte_i;
    q_cmd_o.leader  = !frame_open_q;
    frame_open_d    = frame_open_q;
    if (q_push_o) begin
      frame_open_d = !last_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_open_q <= 1'b0;
    end else begin
      frame_open_q <= frame_open_d;
    end
  end

endmodule

`default_nettype wire

### rtl/core/ipde_queue.sv
// Small command queue between the front end and the segment sequencer.
`timescale 1ns / 1ps
`default_nettype none

module ipde_queue
  import ipde_pkg::*;
#(
  parameter int unsigned Depth = IPDE_CMD_DEPTH
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_i,
  input  wire ipde_cmd_t cmd_i,
  input  wire logic      pop_i,
  output      ipde_cmd_t head_o,
  output      logic      full_o,
  output      logic      empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  ipde_cmd_t             slot_q [Depth];
  logic [PtrW-1:0]       wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]       cnt_q, cnt_d;

  function automatic logic [PtrW-1:0] ptr_next(input logic [PtrW-1:0] p);
    ptr_next = (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  always_comb begin
    full_o   = (cnt_q == CntW'(Depth));
    empty_o  = (cnt_q == '0);
    head_o   = slot_q[rd_ptr_q];
    wr_ptr_d = push_i ? ptr_next(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i ? ptr_next(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

`default_nettype wire

### rtl/core/ipde_back.sv
// Back end: step through the segments of the head command into the result register.
`timescale 1ns / 1ps
`default_nettype none

module ipde_back
  import ipde_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire ipde_cfg_t             cfg_i,
  input  wire ipde_cmd_t             head_i,
  input  wire logic                  q_empty_i,
  output      logic                  q_pop_o,
  input  wire logic                  pop_i,
  output      logic                  empty_o,
  output      logic                  pin_level_o,
  output      logic [IPDE_DUR_W-1:0] duration_us_o,
  output      logic                  last_segment_o,
  output      ipde_back_stat_t       stat_o
);

  logic                  active_q, active_d;
  logic [IPDE_SEG_W-1:0] seg_q, seg_d;
  logic                  out_valid_q, out_valid_d;
  logic                  level_q;
  logic [IPDE_DUR_W-1:0] dur_q;
  logic                  last_q;

  logic [IPDE_SEG_W-1:0] seg_cur, seg_end;
  logic [3:0]            bit_pos;
  logic [2:0]            bit_idx;
  logic                  emit, seg_done;
  logic                  level_nx;
  logic [IPDE_DUR_W-1:0] dur_nx;

  always_comb begin
    seg_cur  = active_q ? seg_q : (head_i.leader ? SEG_LEADER_LOW : SEG_FIRST_MARK);
    seg_end  = head_i.last ? SEG_STOP : SEG_LAST_SPACE;
    seg_done = (seg_cur == seg_end);
    emit     = !q_empty_i && (!out_valid_q || pop_i);
    q_pop_o  = emit && seg_done;

    // Space segments 3, 5, ... 17 carry bits 0 to 7.
    bit_pos  = seg_cur[4:1] - 4'd1;
    bit_idx  = bit_pos[2:0];

    level_nx = (seg_cur == SEG_STOP) ? 1'b0 : seg_cur[0];
    if (seg_cur == SEG_LEADER_LOW) begin
      dur_nx = cfg_i.leader_low;
    end else if (seg_cur == SEG_LEADER_HIGH) begin
      dur_nx = cfg_i.leader_high;
    end else if (seg_cur == SEG_STOP) begin
      dur_nx = cfg_i.stop_low;
    end else if (seg_cur[0]) begin
      dur_nx = head_i.data[bit_idx] ? cfg_i.space_one : cfg_i.space_zero;
    end else begin
      dur_nx = cfg_i.mark;
    end

    active_d    = active_q;
    seg_d       = seg_q;
    out_valid_d = out_valid_q;
    if (emit) begin
      active_d    = !seg_done;
      seg_d       = seg_cur + IPDE_SEG_W'(1);
      out_valid_d = 1'b1;
    end else if (pop_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      seg_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      active_q    <= active_d;
      seg_q       <= seg_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      level_q <= level_nx;
      dur_q   <= dur_nx;
      last_q  <= seg_done;
    end
  end

  assign empty_o        = !out_valid_q;
  assign pin_level_o    = level_q;
  assign duration_us_o  = dur_q;
  assign last_segment_o = last_q;
  assign stat_o.active  = active_q;
  assign stat_o.seg     = seg_q;

endmodule

`default_nettype wire

### rtl/core/infrared_pulse_distance_encoder_core.sv
// Top level of the infrared pulse-distance encoder: registers, front, queue and sequencer.
`timescale 1ns / 1ps
`default_nettype none

// Frame bytes are pushed in one beat at a time and come out as timed pin segments,
// each a level and a duration in microseconds, oldest first from a queue-style result
// port. The first byte after idle gets a leader (low, then high) in front of its bits;
// each bit is a low mark and a high space, short for zero and long for one, least
// significant bit first; a byte flagged last_byte gets a low stop mark after its bits.
// The final segment of every byte carries last_segment. A byte produces 16 segments,
// 18 with a leader, plus one with a stop mark, and the sequencer emits one segment per
// cycle into a single result register while a command is queued and pop is held high.
// A command queue of CmdDepth entries between the front end and the sequencer
// lets bytes be pushed while earlier ones are still going out. The six duration
// registers are written through the cfg port (always ready); indexes above five are
// ignored and only the low 14 bits of the data are kept. Write them only while idle.

module infrared_pulse_distance_encoder_core
  import ipde_pkg::*;
#(
  parameter int unsigned CmdDepth = IPDE_CMD_DEPTH
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  // Byte input
  input  wire logic                      push_i,
  output      logic                      full_o,
  input  wire logic [IPDE_BYTE_W-1:0]    data_byte_i,
  input  wire logic                      last_byte_i,
  // Segment output
  output      logic                      empty_o,
  input  wire logic                      pop_i,
  output      logic                      pin_level_o,
  output      logic [IPDE_DUR_W-1:0]     duration_us_o,
  output      logic                      last_segment_o,
  // Configuration writes
  input  wire logic                      cfg_valid_i,
  output      logic                      cfg_ready_o,
  input  wire logic [IPDE_CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [IPDE_CFG_DAT_W-1:0] cfg_data_i
);

  ipde_cfg_t             cfg_q, cfg_d;
  logic [IPDE_DUR_W-1:0] cfg_val;

  ipde_cmd_t             push_cmd, head_cmd;
  logic                  q_push, q_pop, q_full, q_empty;
  ipde_back_stat_t       back_stat;

  // Duration registers: keep the low 14 bits, drop writes to unknown indexes.
  assign cfg_ready_o = 1'b1;
  assign cfg_val     = cfg_data_i[IPDE_DUR_W-1:0];

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_LEADER_LOW:  cfg_d.leader_low  = cfg_val;
        REG_LEADER_HIGH: cfg_d.leader_high = cfg_val;
        REG_MARK:        cfg_d.mark        = cfg_val;
        REG_SPACE_ZERO:  cfg_d.space_zero  = cfg_val;
        REG_SPACE_ONE:   cfg_d.space_one   = cfg_val;
        REG_STOP_LOW:    cfg_d.stop_low    = cfg_val;
        default:         cfg_d             = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.leader_low  <= IPDE_DUR_W'(9000);
      cfg_q.leader_high <= IPDE_DUR_W'(4560);
      cfg_q.mark        <= IPDE_DUR_W'(500);
      cfg_q.space_zero  <= IPDE_DUR_W'(500);
      cfg_q.space_one   <= IPDE_DUR_W'(1800);
      cfg_q.stop_low    <= IPDE_DUR_W'(560);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Front end: accept a beat when the queue has room and tag it with the leader flag.
  ipde_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push_i),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_cmd_o     (push_cmd)
  );

  assign full_o = q_full;

  // Decouple byte intake from segment output.
  ipde_queue #(
    .Depth (CmdDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (push_cmd),
    .pop_i   (q_pop),
    .head_o  (head_cmd),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  // Sequencer: one segment per cycle given a queued command and a free or draining output.
  ipde_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .head_i         (head_cmd),
    .q_empty_i      (q_empty),
    .q_pop_o        (q_pop),
    .pop_i          (pop_i),
    .empty_o        (empty_o),
    .pin_level_o    (pin_level_o),
    .duration_us_o  (duration_us_o),
    .last_segment_o (last_segment_o),
    .stat_o         (back_stat)
  );

  // The sequencer never walks past the stop segment.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_stat.active |-> (back_stat.seg <= SEG_STOP))
  else $error("segment counter ran past the stop mark");

  // An accepted beat leaves at least one command queued.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !full_o) |=> !q_empty)
  else $error("accepted byte did not reach the command queue");

  // A partly sent byte keeps its command at the queue head.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_stat.active |-> !q_empty)
  else $error("sequencer active with an empty command queue");

  // A stop mark is always a low, final segment.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_pop && head_cmd.last) |=> (last_segment_o && !pin_level_o && !empty_o))
  else $error("frame end not marked on the stop segment");

endmodule

`default_nettype wire

### dv/infrared_pulse_distance_encoder_core_test.sv
// Self-checking testbench of the infrared pulse-distance encoder core.
`timescale 1ns / 1ps

module infrared_pulse_distance_encoder_core_test;
  import ipde_pkg::*;

  localparam int unsigned QUIET_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES = 50;
  localparam logic [IPDE_CFG_IDX_W-1:0] REG_UNUSED_LO = REG_STOP_LOW + 3'd1;
  localparam logic [IPDE_CFG_IDX_W-1:0] REG_UNUSED_HI = '1;
  localparam logic [IPDE_DUR_W-1:0]     DUR_MAX       = '1;

  typedef struct packed {
    logic                  level;
    logic [IPDE_DUR_W-1:0] dur;
    logic                  tail;
  } segment_t;

  logic                      clk_i       = 1'b0;
  logic                      rst_ni      = 1'b0;
  logic                      push_i      = 1'b0;
  logic [IPDE_BYTE_W-1:0]    data_byte_i = '0;
  logic                      last_byte_i = 1'b0;
  logic                      pop_i       = 1'b0;
  logic                      cfg_valid_i = 1'b0;
  logic [IPDE_CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [IPDE_CFG_DAT_W-1:0] cfg_data_i  = '0;
  wire                       full_o;
  wire                       empty_o;
  wire                       pin_level_o;
  wire  [IPDE_DUR_W-1:0]     duration_us_o;
  wire                       last_segment_o;
  wire                       cfg_ready_o;

  // Predicted encoder state: duration registers and the open-frame flag.
  logic [IPDE_DUR_W-1:0] timing [0:REG_STOP_LOW];
  bit                    frame_open   = 1'b0;
  segment_t              pending_segments [$];
  segment_t              want_seg;
  int unsigned           mismatches   = 0;
  int unsigned           items_sent   = 0;
  int unsigned           pop_hold     = 0;
  int unsigned           quiet_cycles = 0;
  bit                    calm         = 1'b0;

  infrared_pulse_distance_encoder_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push_i),
    .full_o        (full_o),
    .data_byte_i   (data_byte_i),
    .last_byte_i   (last_byte_i),
    .empty_o       (empty_o),
    .pop_i         (pop_i),
    .pin_level_o   (pin_level_o),
    .duration_us_o (duration_us_o),
    .last_segment_o(last_segment_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Append the segments that one byte produces and advance the frame state.
  task automatic encode_byte(input logic [IPDE_BYTE_W-1:0] data, input logic last);
    segment_t segs [$];
    if (!frame_open) begin
      segs.push_back('{1'b0, timing[REG_LEADER_LOW], 1'b0});
      segs.push_back('{1'b1, timing[REG_LEADER_HIGH], 1'b0});
    end
    for (int b = 0; b < IPDE_BYTE_W; b++) begin
      segs.push_back('{1'b0, timing[REG_MARK], 1'b0});
      segs.push_back('{1'b1, data[b] ? timing[REG_SPACE_ONE] : timing[REG_SPACE_ZERO], 1'b0});
    end
    if (last) begin
      segs.push_back('{1'b0, timing[REG_STOP_LOW], 1'b0});
    end
    segs[segs.size() - 1].tail = 1'b1;
    foreach (segs[i]) pending_segments.push_back(segs[i]);
    frame_open = !last;
  endtask

  // Push one byte beat, with an occasional gap in front; push stays high afterward.
  task automatic send_byte(input logic [IPDE_BYTE_W-1:0] data, input logic last);
    if (!calm && $urandom_range(0, 3) == 0) begin
      push_i <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    push_i      <= 1'b1;
    data_byte_i <= data;
    last_byte_i <= last;
    do @(posedge clk_i); while (full_o);
    encode_byte(data, last);
    items_sent++;
  endtask

  // Drop push and wait until every predicted segment has come out.
  task automatic finish_phase();
    push_i <= 1'b0;
    while (pending_segments.size() != 0) @(posedge clk_i);
  endtask

  // Write one register beat; valid stays high until close_cfg.
  task automatic write_timing(input logic [IPDE_CFG_IDX_W-1:0] idx,
                              input logic [IPDE_CFG_DAT_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx <= REG_STOP_LOW) timing[idx] = value[IPDE_DUR_W-1:0];
  endtask

  task automatic close_cfg();
    cfg_valid_i <= 1'b0;
  endtask

  task automatic program_all(input logic [IPDE_CFG_DAT_W-1:0] value);
    for (int i = 0; i <= int'(REG_STOP_LOW); i++) write_timing(IPDE_CFG_IDX_W'(i), value);
    close_cfg();
  endtask

  function automatic logic [IPDE_BYTE_W-1:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return IPDE_BYTE_W'($urandom);
    endcase
  endfunction

  // Mostly legal durations, with the extremes, zero and oversized writes mixed in.
  function automatic logic [IPDE_CFG_DAT_W-1:0] pick_duration();
    case ($urandom_range(0, 9))
      0: return IPDE_CFG_DAT_W'(1);
      1: return IPDE_CFG_DAT_W'(DUR_MAX);
      2: return '0;
      3: return IPDE_CFG_DAT_W'($urandom);
      default: return IPDE_CFG_DAT_W'($urandom_range(1, DUR_MAX));
    endcase
  endfunction

  task automatic randomize_timing();
    for (int i = 0; i <= int'(REG_STOP_LOW); i++) begin
      write_timing(IPDE_CFG_IDX_W'(i), pick_duration());
    end
    if ($urandom_range(0, 2) == 0) begin
      write_timing(IPDE_CFG_IDX_W'($urandom_range(REG_UNUSED_LO, REG_UNUSED_HI)),
                   IPDE_CFG_DAT_W'($urandom));
    end
    close_cfg();
  endtask

  // Reset durations: single-byte frames at both data extremes, then a longer frame.
  task automatic test_reset_defaults();
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hA5, 1'b0);
    send_byte(8'h5A, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h80, 1'b1);
    finish_phase();
  endtask

  // Smallest, largest, zero and oversized durations, then writes to unused indexes.
  task automatic test_timing_extremes();
    program_all(IPDE_CFG_DAT_W'(1));
    send_byte(8'h3C, 1'b0);
    send_byte(8'hC3, 1'b1);
    finish_phase();
    program_all(IPDE_CFG_DAT_W'(DUR_MAX));
    send_byte(8'h0F, 1'b0);
    send_byte(8'hF0, 1'b1);
    finish_phase();
    program_all('0);
    send_byte(8'h55, 1'b0);
    send_byte(8'hAA, 1'b1);
    finish_phase();
    // Oversized writes keep only the low duration bits.
    for (int i = 0; i <= int'(REG_STOP_LOW); i++) begin
      write_timing(IPDE_CFG_IDX_W'(i), {2'b11, 14'h2AAA ^ IPDE_DUR_W'(i * 301)});
    end
    close_cfg();
    send_byte(8'h96, 1'b0);
    send_byte(8'h69, 1'b1);
    finish_phase();
    // Unused indexes must leave every duration as it was.
    write_timing(REG_UNUSED_LO, '1);
    write_timing(REG_UNUSED_HI, '0);
    close_cfg();
    send_byte(8'hE7, 1'b0);
    send_byte(8'h18, 1'b1);
    finish_phase();
  endtask

  // Well-formed frames of random length and content, mostly short.
  task automatic test_random_frames(input int unsigned count);
    int unsigned target;
    int unsigned len;
    target = items_sent + count;
    while (items_sent < target) begin
      len = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 8) : $urandom_range(1, 4);
      for (int unsigned i = 0; i < len; i++) send_byte(pick_byte(), i == len - 1);
    end
    finish_phase();
  endtask

  task automatic check_field(input string field, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s expected %0d, actual %0d", $time, field, want, got);
    end
  endtask

  // Pop side: hold pop low in random bursts, none in the calm tail.
  always @(posedge clk_i) begin
    if (pop_hold != 0) begin
      pop_hold = pop_hold - 1;
      pop_i <= 1'b0;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      pop_hold = $urandom_range(1, 14) - 1;
      pop_i <= 1'b0;
    end else begin
      pop_i <= 1'b1;
    end
  end

  // Compare every popped segment with the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && pop_i && !empty_o) begin
      if (pending_segments.size() == 0) begin
        mismatches++;
        $display("%0t: segment expected none, actual level %0d duration %0d last %0d",
                 $time, pin_level_o, duration_us_o, last_segment_o);
      end else begin
        want_seg = pending_segments.pop_front();
        check_field("pin_level", 16'(want_seg.level), 16'(pin_level_o));
        check_field("duration_us", 16'(want_seg.dur), 16'(duration_us_o));
        check_field("last_segment", 16'(want_seg.tail), 16'(last_segment_o));
      end
    end
  end

  // Watchdog: end the run when no beat moves on any channel for too long.
  always @(posedge clk_i) begin
    if ((push_i && !full_o) || (pop_i && !empty_o) || (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no beat accepted for %0d cycles", $time, QUIET_LIMIT);
      $display("FAILED: results differ");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    timing[REG_LEADER_LOW]  = 14'd9000;
    timing[REG_LEADER_HIGH] = 14'd4560;
    timing[REG_MARK]        = 14'd500;
    timing[REG_SPACE_ZERO]  = 14'd500;
    timing[REG_SPACE_ONE]   = 14'd1800;
    timing[REG_STOP_LOW]    = 14'd560;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_reset_defaults();
    test_timing_extremes();
    repeat (6) begin
      randomize_timing();
      test_random_frames(40);
    end
    calm = 1'b1;
    randomize_timing();
    test_random_frames(40);

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    foreach (pending_segments[i]) begin
      mismatches++;
      $display("%0t: segment expected level %0d duration %0d last %0d, actual none",
               $time, pending_segments[i].level, pending_segments[i].dur,
               pending_segments[i].tail);
    end
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
